@@ rtl/core/des_ks_pkg.sv @@
package des_ks_pkg;

	localparam int unsigned HALF_W = 28;
	localparam int unsigned CD_W   = 2 * HALF_W;
	localparam int unsigned KEY_W  = 64;
	localparam int unsigned SUB_W  = 48;
	localparam int unsigned ROUNDS = 16;
	localparam int unsigned RND_W  = $clog2(ROUNDS);

	localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);

	// 1: rotate by two this round, 0: rotate by one
	localparam logic SHIFT_TWO [ROUNDS] = '{
		1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
		1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0
	};

	// positions counted from the most significant bit
	localparam logic [5:0] PC1_TAB [CD_W] = '{
		6'd56, 6'd48, 6'd40, 6'd32, 6'd24, 6'd16, 6'd8,  6'd0,
		6'd57, 6'd49, 6'd41, 6'd33, 6'd25, 6'd17, 6'd9,  6'd1,
		6'd58, 6'd50, 6'd42, 6'd34, 6'd26, 6'd18, 6'd10, 6'd2,
		6'd59, 6'd51, 6'd43, 6'd35, 6'd62, 6'd54, 6'd46, 6'd38,
		6'd30, 6'd22, 6'd14, 6'd6,  6'd61, 6'd53, 6'd45, 6'd37,
		6'd29, 6'd21, 6'd13, 6'd5,  6'd60, 6'd52, 6'd44, 6'd36,
		6'd28, 6'd20, 6'd12, 6'd4,  6'd27, 6'd19, 6'd11, 6'd3
	};

	localparam logic [5:0] PC2_TAB [SUB_W] = '{
		6'd13, 6'd16, 6'd10, 6'd23, 6'd0,  6'd4,  6'd2,  6'd27,
		6'd14, 6'd5,  6'd20, 6'd9,  6'd22, 6'd18, 6'd11, 6'd3,
		6'd25, 6'd7,  6'd15, 6'd6,  6'd26, 6'd19, 6'd12, 6'd1,
		6'd40, 6'd51, 6'd30, 6'd36, 6'd46, 6'd54, 6'd29, 6'd39,
		6'd50, 6'd44, 6'd32, 6'd47, 6'd43, 6'd48, 6'd38, 6'd55,
		6'd33, 6'd52, 6'd45, 6'd41, 6'd49, 6'd35, 6'd28, 6'd31
	};

	typedef struct packed {
		logic [KEY_W-1:0] key;
	} key_item_t;

	typedef struct packed {
		logic [SUB_W-1:0] subkey;
		logic [RND_W-1:0] round_number;
		logic             last;
	} subkey_item_t;

	typedef struct packed {
		logic              valid;
		logic [HALF_W-1:0] c_half;
		logic [HALF_W-1:0] d_half;
	} halves_t;

	typedef struct packed {
		logic             valid;
		logic [CD_W-1:0]  cd;
		logic [RND_W-1:0] round_number;
	} round_t;

	function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] k);
		logic [CD_W-1:0] r;
		r = '0;
		for (int i = 0; i < CD_W; i++) begin
			r[CD_W-1-i] = k[KEY_W-1-int'(PC1_TAB[i])];
		end
		return r;
	endfunction

	function automatic logic [SUB_W-1:0] pc2(input logic [CD_W-1:0] cd);
		logic [SUB_W-1:0] r;
		r = '0;
		for (int i = 0; i < SUB_W; i++) begin
			r[SUB_W-1-i] = cd[CD_W-1-int'(PC2_TAB[i])];
		end
		return r;
	endfunction

	function automatic logic [HALF_W-1:0] rot28(input logic [HALF_W-1:0] x, input logic two);
		logic [HALF_W-1:0] r;
		if (two) begin
			r = {x[HALF_W-3:0], x[HALF_W-1:HALF_W-2]};
		end else begin
			r = {x[HALF_W-2:0], x[HALF_W-1]};
		end
		return r;
	endfunction

endpackage

@@ rtl/core/des_ks_stream_if.sv @@
interface des_ks_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/des_ks_pc1.sv @@
module des_ks_pc1 (
	input  logic                clk,
	input  logic                arst_n,
	des_ks_stream_if.sink       key_ch,
	output des_ks_pkg::halves_t s1,
	input  logic                s1_ready
);
	import des_ks_pkg::*;

	logic              valid_s1;
	logic [CD_W-1:0]   cd_s1;

	assign key_ch.ready = !valid_s1 || s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_ch.ready) begin
			valid_s1 <= key_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_ch.valid && key_ch.ready) begin
			cd_s1 <= pc1(key_ch.data.key);
		end
	end

	assign s1.valid  = valid_s1;
	assign s1.c_half = cd_s1[CD_W-1:HALF_W];
	assign s1.d_half = cd_s1[HALF_W-1:0];
endmodule

@@ rtl/core/des_ks_round.sv @@
module des_ks_round (
	input  logic                clk,
	input  logic                arst_n,
	input  des_ks_pkg::halves_t s1,
	output logic                s1_ready,
	output des_ks_pkg::round_t  s3,
	input  logic                s3_ready
);
	import des_ks_pkg::*;

	logic              valid_s2;
	logic [HALF_W-1:0] c_s2;
	logic [HALF_W-1:0] d_s2;
	logic [RND_W-1:0]  round_s2;

	logic              valid_s3;
	logic [CD_W-1:0]   cd_s3;
	logic [RND_W-1:0]  round_s3;

	logic              rdy3;
	logic              issue;
	logic              two;
	logic [HALF_W-1:0] c_rot;
	logic [HALF_W-1:0] d_rot;

	assign rdy3     = !valid_s3 || s3_ready;
	assign issue    = valid_s2 && rdy3;
	assign s1_ready = !valid_s2 || (issue && round_s2 == LAST_ROUND);
	assign two      = SHIFT_TWO[round_s2];
	assign c_rot    = rot28(c_s2, two);
	assign d_rot    = rot28(d_s2, two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			round_s2 <= '0;
			valid_s3 <= 1'b0;
		end else begin
			if (s1.valid && s1_ready) begin
				valid_s2 <= 1'b1;
				round_s2 <= '0;
			end else if (issue) begin
				if (round_s2 == LAST_ROUND) begin
					valid_s2 <= 1'b0;
				end
				round_s2 <= round_s2 + 1'b1;
			end
			if (rdy3) begin
				valid_s3 <= issue;
			end
		end
	end

	// halves keep rotating; a new key reloads them
	always_ff @(posedge clk) begin
		if (s1.valid && s1_ready) begin
			c_s2 <= s1.c_half;
			d_s2 <= s1.d_half;
		end else if (issue) begin
			c_s2 <= c_rot;
			d_s2 <= d_rot;
		end
		if (issue) begin
			cd_s3    <= {c_rot, d_rot};
			round_s3 <= round_s2;
		end
	end

	assign s3.valid        = valid_s3;
	assign s3.cd           = cd_s3;
	assign s3.round_number = round_s3;
endmodule

@@ rtl/core/des_ks_pc2.sv @@
module des_ks_pc2 (
	input  logic               clk,
	input  logic               arst_n,
	input  des_ks_pkg::round_t s3,
	output logic               s3_ready,
	des_ks_stream_if.source    subkey_ch
);
	import des_ks_pkg::*;

	logic         valid_s4;
	subkey_item_t item_s4;

	assign s3_ready = !valid_s4 || subkey_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (s3_ready) begin
			valid_s4 <= s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3.valid && s3_ready) begin
			item_s4.subkey       <= pc2(s3.cd);
			item_s4.round_number <= s3.round_number;
			item_s4.last         <= (s3.round_number == LAST_ROUND);
		end
	end

	assign subkey_ch.valid = valid_s4;
	assign subkey_ch.data  = item_s4;
endmodule

@@ rtl/core/des_key_schedule.sv @@
// DES key schedule. Each key accepted on key_ch yields sixteen 48-bit round
// subkeys on subkey_ch, rounds 0 to 15 in order, with last set on round 15.
// A key occupies the round iterator for all of its rounds, one subkey
// issued per cycle while subkey_ch does not stall; the next key is taken
// in while the previous one is still draining. Each key passes through
// the PC-1, rotate and PC-2 stages in order. Backpressure on subkey_ch
// stalls the stages in place without loss.
module des_key_schedule (
	input  logic          clk,
	input  logic          arst_n,
	des_ks_stream_if.sink   key_ch,
	des_ks_stream_if.source subkey_ch
);
	import des_ks_pkg::*;

	halves_t s1;
	logic    s1_ready;
	round_t  s3;
	logic    s3_ready;

	des_ks_pc1 u_pc1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_ch   (key_ch),
		.s1       (s1),
		.s1_ready (s1_ready)
	);

	des_ks_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1       (s1),
		.s1_ready (s1_ready),
		.s3       (s3),
		.s3_ready (s3_ready)
	);

	des_ks_pc2 u_pc2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.s3        (s3),
		.s3_ready  (s3_ready),
		.subkey_ch (subkey_ch)
	);

	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		subkey_ch.valid |->
			(subkey_ch.data.last == (subkey_ch.data.round_number == LAST_ROUND)))
		else $error("last flag does not match round number");

	a_key_lands: assert property (@(posedge clk) disable iff (!arst_n)
		key_ch.valid && key_ch.ready |=> s1.valid)
		else $error("accepted key lost before round stage");

	a_round_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s3.valid && s3_ready |=> subkey_ch.valid)
		else $error("rotated halves lost before output");
endmodule
